>>> rtl/core/wsm_pkg.sv
package wsm_pkg;

  // Widest window position and count over the whole MAX_SAMPLES range (up to 65536)
  localparam int unsigned CntMaxW = 17;

  // Shared arithmetic datapath width and iteration counts
  localparam int unsigned ArithW   = 64;
  localparam int unsigned MulSteps  = 34;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned SqrtTopBit = 30;

  typedef struct packed {
    logic [CntMaxW-1:0] start;
    logic [CntMaxW-1:0] count;
  } meas_req_t;

  typedef enum logic [1:0] {
    OpMul  = 2'd0,
    OpDiv  = 2'd1,
    OpSqrt = 2'd2
  } arith_op_e;

endpackage

>>> rtl/core/waveform_statistics_measure.sv
// Waveform statistics over a window of the newest MAX_SAMPLES samples.
// Input channel (in_valid_i/in_ready_o): one request per sample carrying its
// time stamp, Q3.12 value and a last flag. Samples go into the window at one
// per cycle while in_ready_o is high; a full window drops its oldest sample.
// A sample with last_sample_i set closes the window and queues a measurement.
// Output channel (out_valid_o/out_ready_i): one request per closed window with
// min/max and their first positions, mean, peak-to-peak, standard deviation,
// mean crossings, period, frequency and period_valid.
// Each measurement takes two read passes over the sample memory (one entry per
// cycle) plus a shared shift-add multiply / restoring divide / square root unit
// that runs three multiplies, up to four divides and one square root.
// In_ready_o stays low while a measurement runs.
// The result sits in an output register; while a stalled receiver still holds
// the previous result, the next one waits and sampling stays off. Sampling
// resumes as soon as the result has been registered.
// Reset empties the window and the request queue; memory contents are kept.
module waveform_statistics_measure import wsm_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] time_stamp_i,
  input  logic [15:0] sample_value_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] min_value_o,
  output logic [13:0] min_index_o,
  output logic [15:0] max_value_o,
  output logic [13:0] max_index_o,
  output logic [15:0] mean_value_o,
  output logic [15:0] peak_to_peak_o,
  output logic [15:0] std_dev_o,
  output logic [13:0] crossing_count_o,
  output logic [32:0] period_ticks_o,
  output logic [32:0] frequency_o,
  output logic        period_valid_o,
  output logic [14:0] sample_count_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          push, pop, q_empty, q_full, back_active, rd_en;
  meas_req_t     push_req, head_req;
  logic [15:0]   sample_rdata;
  logic [31:0]   time_rdata;

  wsm_front #(
    .MaxSamples(MAX_SAMPLES),
    .AW        (AW),
    .CW        (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .last_sample_i(last_sample_i),
    .busy_i       (!q_empty || q_full || back_active),
    .we_o         (we),
    .waddr_o      (waddr),
    .push_o       (push),
    .req_o        (push_req)
  );

  wsm_req_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (push_req),
    .pop_i  (pop),
    .empty_o(q_empty),
    .full_o (q_full),
    .req_o  (head_req)
  );

  wsm_ram #(
    .Width(16),
    .Depth(MAX_SAMPLES)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(sample_value_i),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(sample_rdata)
  );

  wsm_ram #(
    .Width(32),
    .Depth(MAX_SAMPLES)
  ) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(time_stamp_i),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(time_rdata)
  );

  wsm_back #(
    .MaxSamples(MAX_SAMPLES),
    .AW        (AW),
    .CW        (CW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (!q_empty),
    .req_i           (head_req),
    .req_pop_o       (pop),
    .active_o        (back_active),
    .rd_en_o         (rd_en),
    .raddr_o         (raddr),
    .sample_rdata_i  (sample_rdata),
    .time_rdata_i    (time_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .min_value_o     (min_value_o),
    .min_index_o     (min_index_o),
    .max_value_o     (max_value_o),
    .max_index_o     (max_index_o),
    .mean_value_o    (mean_value_o),
    .peak_to_peak_o  (peak_to_peak_o),
    .std_dev_o       (std_dev_o),
    .crossing_count_o(crossing_count_o),
    .period_ticks_o  (period_ticks_o),
    .frequency_o     (frequency_o),
    .period_valid_o  (period_valid_o),
    .sample_count_o  (sample_count_o)
  );

endmodule

>>> rtl/core/wsm_ram.sv
module wsm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/wsm_req_fifo.sv
module wsm_req_fifo import wsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  meas_req_t req_i,
  input  logic      pop_i,
  output logic      empty_o,
  output logic      full_o,
  output meas_req_t req_o
);

  meas_req_t   entry_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = entry_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= req_i;
    end
  end

endmodule

>>> rtl/core/wsm_front.sv
module wsm_front import wsm_pkg::*; #(
  parameter int unsigned MaxSamples = 16384,
  parameter int unsigned AW = $clog2(MaxSamples),
  parameter int unsigned CW = $clog2(MaxSamples + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          last_sample_i,
  input  logic          busy_i,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic          push_o,
  output meas_req_t     req_o
);

  logic [AW-1:0] wp_q, wp_d, wp_inc;
  logic [CW-1:0] fill_q, fill_d, fill_inc;
  logic [CW:0]   wp_ext, n_ext, start_ext;
  logic          accept;

  assign in_ready_o = !busy_i;
  assign accept     = in_valid_i && !busy_i;
  assign we_o       = accept;
  assign waddr_o    = wp_q;

  assign wp_inc   = (wp_q == AW'(MaxSamples - 1)) ? '0 : wp_q + AW'(1);
  assign fill_inc = (fill_q == CW'(MaxSamples)) ? fill_q : fill_q + CW'(1);

  // Oldest position of the window once this sample is in
  assign wp_ext    = (CW + 1)'(wp_inc);
  assign n_ext     = (CW + 1)'(fill_inc);
  assign start_ext = (wp_ext >= n_ext) ? wp_ext - n_ext
                                       : wp_ext + (CW + 1)'(MaxSamples) - n_ext;

  assign push_o      = accept && last_sample_i;
  assign req_o.start = CntMaxW'(start_ext);
  assign req_o.count = CntMaxW'(fill_inc);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (accept) begin
      if (last_sample_i) begin
        wp_d   = '0;
        fill_d = '0;
      end else begin
        wp_d   = wp_inc;
        fill_d = fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> rtl/core/wsm_arith.sv
module wsm_arith import wsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  arith_op_e         op_i,
  input  logic [ArithW-1:0] a_i,
  input  logic [ArithW-1:0] b_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [ArithW-1:0] res_o,
  output logic [ArithW-1:0] rem_o
);

  arith_op_e         op_q;
  logic [ArithW-1:0] acc_q, acc_d;
  logic [ArithW-1:0] aux_q, aux_d;
  logic [ArithW-1:0] sel_q, sel_d;
  logic [6:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ArithW:0]   rem_sh, rem_sub;
  logic [ArithW-1:0] trial;

  assign rem_sh  = {acc_q, aux_q[ArithW-1]};
  assign rem_sub = rem_sh - {1'b0, sel_q};
  assign trial   = aux_q + sel_q;

  always_comb begin
    acc_d  = acc_q;
    aux_d  = aux_q;
    sel_d  = sel_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      case (op_i)
        OpMul: begin
          acc_d = '0;
          aux_d = a_i;
          sel_d = b_i;
          cnt_d = 7'(MulSteps);
        end
        OpDiv: begin
          acc_d = '0;
          aux_d = a_i;
          sel_d = b_i;
          cnt_d = 7'(DivSteps);
        end
        OpSqrt: begin
          acc_d = a_i;
          aux_d = '0;
          sel_d = ArithW'(1) << SqrtTopBit;
          cnt_d = 7'(SqrtSteps);
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OpMul: begin
          if (sel_q[0]) begin
            acc_d = acc_q + aux_q;
          end
          aux_d = aux_q << 1;
          sel_d = sel_q >> 1;
        end
        OpDiv: begin
          if (!rem_sub[ArithW]) begin
            acc_d = rem_sub[ArithW-1:0];
            aux_d = {aux_q[ArithW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[ArithW-1:0];
            aux_d = {aux_q[ArithW-2:0], 1'b0};
          end
        end
        OpSqrt: begin
          if (acc_q >= trial) begin
            acc_d = acc_q - trial;
            aux_d = (aux_q >> 1) + sel_q;
          end else begin
            aux_d = aux_q >> 1;
          end
          sel_d = sel_q >> 2;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    aux_q <= aux_d;
    sel_q <= sel_d;
    if (start_i) begin
      op_q <= op_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = (op_q == OpMul) ? acc_q : aux_q;
  assign rem_o  = acc_q;

endmodule

>>> rtl/core/wsm_back.sv
module wsm_back import wsm_pkg::*; #(
  parameter int unsigned MaxSamples = 16384,
  parameter int unsigned AW = $clog2(MaxSamples),
  parameter int unsigned CW = $clog2(MaxSamples + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  meas_req_t     req_i,
  output logic          req_pop_o,
  output logic          active_o,
  output logic          rd_en_o,
  output logic [AW-1:0] raddr_o,
  input  logic [15:0]   sample_rdata_i,
  input  logic [31:0]   time_rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   min_value_o,
  output logic [13:0]   min_index_o,
  output logic [15:0]   max_value_o,
  output logic [13:0]   max_index_o,
  output logic [15:0]   mean_value_o,
  output logic [15:0]   peak_to_peak_o,
  output logic [15:0]   std_dev_o,
  output logic [13:0]   crossing_count_o,
  output logic [32:0]   period_ticks_o,
  output logic [32:0]   frequency_o,
  output logic          period_valid_o,
  output logic [14:0]   sample_count_o
);

  localparam int unsigned SW = 16 + CW;  // signed sum
  localparam int unsigned QW = 31 + CW;  // sum of squares
  localparam int unsigned PW = 17 + CW;  // sample times count

  typedef enum logic [11:0] {
    StIdle  = 12'b0000_0000_0001,
    StPass1 = 12'b0000_0000_0010,
    StMean  = 12'b0000_0000_0100,
    StMulA  = 12'b0000_0000_1000,
    StMulB  = 12'b0000_0001_0000,
    StMulNn = 12'b0000_0010_0000,
    StVar   = 12'b0000_0100_0000,
    StSqrt  = 12'b0000_1000_0000,
    StPass2 = 12'b0001_0000_0000,
    StPer   = 12'b0010_0000_0000,
    StFreq  = 12'b0100_0000_0000,
    StOut   = 12'b1000_0000_0000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CW-1:0]        n_q, n_d;
  logic [AW-1:0]        start_q, start_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [CW-1:0]        issue_q, issue_d;
  logic [CW-1:0]        ridx_q, ridx_d;
  logic                 rv_q, rv_d;
  logic                 issued_q, issued_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [QW-1:0]        sumsq_q, sumsq_d;
  logic signed [15:0]   mn_q, mn_d, mx_q, mx_d;
  logic [CW-1:0]        mni_q, mni_d, mxi_q, mxi_d;
  logic [31:0]          t0_q, t0_d, tl_q, tl_d;
  logic [15:0]          mean_q, mean_d;
  logic [ArithW-1:0]    pa_q, pa_d;
  logic [ArithW-1:0]    num_q, num_d;
  logic [ArithW-1:0]    nn_q, nn_d;
  logic [31:0]          var_q, var_d;
  logic [15:0]          sd_q, sd_d;
  logic [CW-1:0]        cross_q, cross_d;
  logic                 above_q, above_d, below_q, below_d;
  logic [32:0]          period_q, period_d;
  logic [32:0]          freq_q, freq_d;
  logic                 valid_q, valid_d;
  logic                 out_valid_q;
  logic                 load;

  logic                 rd_en;
  logic                 arith_start, arith_busy, arith_done;
  arith_op_e            arith_op;
  logic [ArithW-1:0]    arith_a, arith_b, arith_res, arith_rem;

  logic signed [15:0]   v_s;
  logic signed [31:0]   sq_s;
  logic signed [PW-1:0] prod_s, sum_ext;
  logic                 above, below;
  logic                 sum_neg;
  logic [SW-1:0]        abs_sum;
  logic [ArithW-1:0]    q_adj;
  logic [31:0]          span;
  logic                 last_rd;

  wsm_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(arith_start),
    .op_i   (arith_op),
    .a_i    (arith_a),
    .b_i    (arith_b),
    .busy_o (arith_busy),
    .done_o (arith_done),
    .res_o  (arith_res),
    .rem_o  (arith_rem)
  );

  assign v_s     = $signed(sample_rdata_i);
  assign sq_s    = v_s * v_s;
  assign prod_s  = v_s * $signed({1'b0, n_q});
  assign sum_ext = PW'(sum_q);
  assign above   = prod_s > sum_ext;
  assign below   = prod_s < sum_ext;
  assign sum_neg = sum_q[SW-1];
  assign abs_sum = sum_neg ? SW'(-sum_q) : SW'(sum_q);
  assign q_adj   = arith_res + ArithW'(arith_rem != '0);
  assign span    = tl_q - t0_q;
  assign last_rd = rv_q && (ridx_q == n_q - CW'(1));

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    start_d     = start_q;
    addr_d      = addr_q;
    issue_d     = issue_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    mni_d       = mni_q;
    mxi_d       = mxi_q;
    t0_d        = t0_q;
    tl_d        = tl_q;
    mean_d      = mean_q;
    pa_d        = pa_q;
    num_d       = num_q;
    nn_d        = nn_q;
    var_d       = var_q;
    sd_d        = sd_q;
    cross_d     = cross_q;
    above_d     = above_q;
    below_d     = below_q;
    period_d    = period_q;
    freq_d      = freq_q;
    valid_d     = valid_q;
    rd_en       = 1'b0;
    req_pop_o   = 1'b0;
    load        = 1'b0;
    arith_start = 1'b0;
    arith_op    = OpMul;
    arith_a     = '0;
    arith_b     = '0;

    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          n_d       = CW'(req_i.count);
          start_d   = AW'(req_i.start);
          addr_d    = AW'(req_i.start);
          issue_d   = '0;
          sum_d     = '0;
          sumsq_d   = '0;
          state_d   = StPass1;
        end
      end
      StPass1: begin
        if (issue_q < n_q) begin
          rd_en   = 1'b1;
          issue_d = issue_q + CW'(1);
          addr_d  = (addr_q == AW'(MaxSamples - 1)) ? '0 : addr_q + AW'(1);
        end
        if (rv_q) begin
          sum_d   = sum_q + SW'(v_s);
          sumsq_d = sumsq_q + QW'($unsigned(sq_s));
          if (ridx_q == '0) begin
            mn_d  = v_s;
            mx_d  = v_s;
            mni_d = '0;
            mxi_d = '0;
            t0_d  = time_rdata_i;
          end else begin
            if (v_s < mn_q) begin
              mn_d  = v_s;
              mni_d = ridx_q;
            end
            if (v_s > mx_q) begin
              mx_d  = v_s;
              mxi_d = ridx_q;
            end
          end
          if (last_rd) begin
            tl_d    = time_rdata_i;
            state_d = StMean;
          end
        end
      end
      StMean: begin
        arith_op    = OpDiv;
        arith_a     = ArithW'(abs_sum);
        arith_b     = ArithW'(n_q);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          // floor toward minus infinity for a negative sum
          mean_d  = sum_neg ? 16'(~q_adj + ArithW'(1)) : arith_res[15:0];
          state_d = StMulA;
        end
      end
      StMulA: begin
        arith_op    = OpMul;
        arith_a     = ArithW'(sumsq_q);
        arith_b     = ArithW'(n_q);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          pa_d    = arith_res;
          state_d = StMulB;
        end
      end
      StMulB: begin
        arith_op    = OpMul;
        arith_a     = ArithW'(abs_sum);
        arith_b     = ArithW'(abs_sum);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          num_d   = (pa_q > arith_res) ? pa_q - arith_res : '0;
          state_d = StMulNn;
        end
      end
      StMulNn: begin
        arith_op    = OpMul;
        arith_a     = ArithW'(n_q);
        arith_b     = ArithW'(n_q);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          nn_d    = arith_res;
          state_d = StVar;
        end
      end
      StVar: begin
        arith_op    = OpDiv;
        arith_a     = num_q;
        arith_b     = nn_q;
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          var_d   = arith_res[31:0];
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        arith_op    = OpSqrt;
        arith_a     = ArithW'(var_q);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          sd_d    = arith_res[15:0];
          issue_d = '0;
          addr_d  = start_q;
          cross_d = '0;
          state_d = StPass2;
        end
      end
      StPass2: begin
        if (issue_q < n_q) begin
          rd_en   = 1'b1;
          issue_d = issue_q + CW'(1);
          addr_d  = (addr_q == AW'(MaxSamples - 1)) ? '0 : addr_q + AW'(1);
        end
        if (rv_q) begin
          if ((ridx_q != '0) && ((below_q && above) || (above_q && below))) begin
            cross_d = cross_q + CW'(1);
          end
          above_d = above;
          below_d = below;
          if (last_rd) begin
            state_d = StPer;
          end
        end
      end
      StPer: begin
        if (cross_q == '0) begin
          period_d = '0;
          freq_d   = '0;
          valid_d  = 1'b0;
          state_d  = StOut;
        end else begin
          arith_op    = OpDiv;
          arith_a     = ArithW'({span, 1'b0});
          arith_b     = ArithW'(cross_q);
          arith_start = !issued_q;
          if (issued_q && arith_done) begin
            period_d = arith_res[32:0];
            if (arith_res == '0) begin
              freq_d  = '0;
              valid_d = 1'b0;
              state_d = StOut;
            end else begin
              state_d = StFreq;
            end
          end
        end
      end
      StFreq: begin
        arith_op    = OpDiv;
        arith_a     = ArithW'(1) << 32;
        arith_b     = ArithW'(period_q);
        arith_start = !issued_q;
        if (issued_q && arith_done) begin
          freq_d  = arith_res[32:0];
          valid_d = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        // hold until the result register frees up
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    rv_d     = rd_en;
    ridx_d   = issue_q;
    issued_d = arith_start ? 1'b1 : (arith_done ? 1'b0 : issued_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rv_q        <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      issued_q    <= issued_d;
      out_valid_q <= load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    start_q  <= start_d;
    addr_q   <= addr_d;
    issue_q  <= issue_d;
    ridx_q   <= ridx_d;
    sum_q    <= sum_d;
    sumsq_q  <= sumsq_d;
    mn_q     <= mn_d;
    mx_q     <= mx_d;
    mni_q    <= mni_d;
    mxi_q    <= mxi_d;
    t0_q     <= t0_d;
    tl_q     <= tl_d;
    mean_q   <= mean_d;
    pa_q     <= pa_d;
    num_q    <= num_d;
    nn_q     <= nn_d;
    var_q    <= var_d;
    sd_q     <= sd_d;
    cross_q  <= cross_d;
    above_q  <= above_d;
    below_q  <= below_d;
    period_q <= period_d;
    freq_q   <= freq_d;
    valid_q  <= valid_d;
  end

  logic [ArithW-1:0] mni_w, mxi_w, cross_w, n_w;
  logic signed [16:0] p2p_s;

  assign mni_w   = ArithW'(mni_q);
  assign mxi_w   = ArithW'(mxi_q);
  assign cross_w = ArithW'(cross_q);
  assign n_w     = ArithW'(n_q);
  assign p2p_s   = 17'(mx_q) - 17'(mn_q);

  always_ff @(posedge clk_i) begin
    if (load) begin
      min_value_o      <= mn_q;
      min_index_o      <= mni_w[13:0];
      max_value_o      <= mx_q;
      max_index_o      <= mxi_w[13:0];
      mean_value_o     <= mean_q;
      peak_to_peak_o   <= p2p_s[15:0];
      std_dev_o        <= sd_q;
      crossing_count_o <= cross_w[13:0];
      period_ticks_o   <= period_q;
      frequency_o      <= freq_q;
      period_valid_o   <= valid_q;
      sample_count_o   <= n_w[14:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign active_o    = (state_q != StIdle);
  assign rd_en_o     = rd_en;
  assign raddr_o     = addr_q;

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_start |-> !arith_busy)
    else $error("arith unit started while busy");

  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMean) |-> (mn_q <= mx_q))
    else $error("min above max after first pass");

  a_cross_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPer || state_q == StFreq) |-> (cross_q < n_q))
    else $error("crossing count not below sample count");

endmodule

>>> verif/waveform_statistics_measure_test.sv
module waveform_statistics_measure_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinDepth = 16384;

  typedef struct {
    logic [31:0] stamp;
    logic [15:0] value;
    logic        last;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] min_value;
    logic [13:0] min_index;
    logic [15:0] max_value;
    logic [13:0] max_index;
    logic [15:0] mean_value;
    logic [15:0] peak_to_peak;
    logic [15:0] std_dev;
    logic [13:0] crossing_count;
    logic [32:0] period_ticks;
    logic [32:0] frequency;
    logic        period_valid;
    logic [14:0] sample_count;
  } stats_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] time_stamp_i;
  logic [15:0] sample_value_i;
  logic        last_sample_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] min_value_o;
  logic [13:0] min_index_o;
  logic [15:0] max_value_o;
  logic [13:0] max_index_o;
  logic [15:0] mean_value_o;
  logic [15:0] peak_to_peak_o;
  logic [15:0] std_dev_o;
  logic [13:0] crossing_count_o;
  logic [32:0] period_ticks_o;
  logic [32:0] frequency_o;
  logic        period_valid_o;
  logic [14:0] sample_count_o;

  waveform_statistics_measure u_top (.*);

  sample_req_t pending_samples[$];
  stats_t      expected_stats[$];

  // predictor window
  logic signed [15:0] win_value[WinDepth];
  logic [31:0]        win_stamp[WinDepth];
  int unsigned        win_wr;
  int unsigned        win_fill;

  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off;
  bit  in_taken;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic stats_t measure_window();
    stats_t s;
    int unsigned n, start, p, q, mn_i, mx_i, crossings;
    longint signed sum, mean, mn, mx, v, a, b;
    longint unsigned sumsq, sq_a, sq_b, num, span, period, freq, abs_sum;
    n = win_fill;
    start = (win_wr >= n) ? win_wr - n : win_wr + WinDepth - n;
    mn = win_value[start];
    mx = mn;
    mn_i = 0;
    mx_i = 0;
    sum = 0;
    sumsq = 0;
    crossings = 0;
    for (int unsigned i = 0; i < n; i++) begin
      p = (start + i) % WinDepth;
      v = win_value[p];
      sum += v;
      sumsq += longint'(v * v);
      if (v < mn) begin
        mn = v;
        mn_i = i;
      end
      if (v > mx) begin
        mx = v;
        mx_i = i;
      end
    end
    mean = sum / longint'(n);
    if (sum % longint'(n) != 0 && sum < 0) mean -= 1;
    abs_sum = (sum < 0) ? -sum : sum;
    sq_a = longint'(n) * sumsq;
    sq_b = abs_sum * abs_sum;
    num = (sq_a > sq_b) ? sq_a - sq_b : 0;
    for (int unsigned i = 1; i < n; i++) begin
      p = (start + i - 1) % WinDepth;
      q = (start + i) % WinDepth;
      a = longint'(win_value[p]) * longint'(n);
      b = longint'(win_value[q]) * longint'(n);
      if ((a < sum && b > sum) || (a > sum && b < sum)) crossings++;
    end
    span = 32'(win_stamp[(start + n - 1) % WinDepth] - win_stamp[start]);
    period = 0;
    freq = 0;
    s.period_valid = 1'b0;
    if (crossings > 0) begin
      period = (2 * span) / crossings;
      if (period > 0) begin
        s.period_valid = 1'b1;
        freq = (64'd1 << 32) / period;
      end
    end
    s.min_value = 16'(mn);
    s.min_index = 14'(mn_i);
    s.max_value = 16'(mx);
    s.max_index = 14'(mx_i);
    s.mean_value = 16'(mean);
    s.peak_to_peak = 16'(mx - mn);
    s.std_dev = 16'(floor_sqrt(num / (longint'(n) * longint'(n))));
    s.crossing_count = 14'(crossings);
    s.period_ticks = 33'(period);
    s.frequency = 33'(freq);
    s.sample_count = 15'(n);
    return s;
  endfunction

  function automatic void store_sample(sample_req_t r);
    win_value[win_wr] = r.value;
    win_stamp[win_wr] = r.stamp;
    win_wr = (win_wr + 1) % WinDepth;
    if (win_fill < WinDepth) win_fill++;
    if (r.last) begin
      expected_stats.push_back(measure_window());
      win_wr = 0;
      win_fill = 0;
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((!in_valid_i || in_taken) && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid_i     <= 1'b1;
        time_stamp_i   <= pending_samples[0].stamp;
        sample_value_i <= pending_samples[0].value;
        last_sample_i  <= pending_samples[0].last;
      end else if (!in_valid_i || in_taken) begin
        in_valid_i <= 1'b0;
      end
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // count down the long receiver hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor: predict on accept, check results
  always @(posedge clk_i) begin
    stats_t g, e;
    if (rst_ni) begin
      in_taken = 1'b0;
      if (in_valid_i && in_ready_o) begin
        store_sample(pending_samples.pop_front());
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        g = '{min_value_o, min_index_o, max_value_o, max_index_o, mean_value_o,
              peak_to_peak_o, std_dev_o, crossing_count_o, period_ticks_o,
              frequency_o, period_valid_o, sample_count_o};
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, g);
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (g !== e) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, e, g);
            errors++;
          end
        end
      end
    end
  end

  function automatic void add_window(int unsigned len, int shape);
    sample_req_t r;
    logic [31:0] t;
    int unsigned step, amp, half;
    t = $urandom();
    step = $urandom_range(1, 300);
    amp = $urandom_range(1, 32767);
    half = $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      r.stamp = t;
      case (shape)
        0: r.value = $urandom();
        1: r.value = ((i / half) % 2) ? 16'(-amp) : 16'(amp);
        default: r.value = 16'($urandom_range(0, 2 * amp) - amp);
      endcase
      r.last = (i == len - 1);
      pending_samples.push_back(r);
      t += ($urandom_range(9) == 0) ? $urandom() : step;
    end
  endfunction

  function automatic void add_one(logic [31:0] t, logic [15:0] v, logic l);
    sample_req_t r;
    r.stamp = t;
    r.value = v;
    r.last = l;
    pending_samples.push_back(r);
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || expected_stats.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int items;
    errors = 0;
    win_wr = 0;
    win_fill = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    time_stamp_i = '0;
    sample_value_i = '0;
    last_sample_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single sample, extremes, equal samples, zero period, wrapped span
    add_one(32'hFFFF_FFFF, 16'h8000, 1'b1);
    add_one(32'h0, 16'h7FFF, 1'b1);
    add_one(32'hFFFF_FFF0, 16'h8000, 1'b0);
    add_one(32'h0000_0010, 16'h7FFF, 1'b0);
    add_one(32'h0000_0020, 16'h8000, 1'b0);
    add_one(32'h0000_0030, 16'h7FFF, 1'b1);
    add_one(32'd5, 16'd100, 1'b0);
    add_one(32'd5, 16'hFF9C, 1'b0);
    add_one(32'd5, 16'd100, 1'b1);
    add_one(32'd1, 16'd7, 1'b0);
    add_one(32'd9, 16'd7, 1'b0);
    add_one(32'd12, 16'd7, 1'b1);
    add_one(32'd0, 16'h8000, 1'b0);
    add_one(32'd1, 16'h7FFF, 1'b1);
    add_one(32'h5555_5555, 16'h5555, 1'b0);
    add_one(32'hAAAA_AAAA, 16'hAAAA, 1'b1);
    drain();

    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 29) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 29) : 0;
      if (ph == 0) hold_off = 3000;
      items = 0;
      while (items < 350) begin
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
        add_window(len, $urandom_range(2));
        items += len;
      end
      drain();
    end
    repeat (1000) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
